// File: sv/kqbp_pkg.sv
// ----------------------------------------------------------------------------
// kqbp_pkg
// Shared constants for the keypoint quantizer and bit packer.
// ----------------------------------------------------------------------------
package kqbp_pkg;

   // fixed field widths
   localparam int FRAME_W      = 15;   // frame dimension registers
   localparam int X_POS_W      = 18;
   localparam int Y_POS_W      = 18;
   localparam int DIAM_W       = 16;
   localparam int ANGLE_IN_W   = 14;
   localparam int BYTE_BITS    = 8;
   localparam int SIZE_BITS    = 10;   // quantized size field
   localparam int ANGLE_BITS   = 9;    // sign + 8 magnitude bits
   localparam int COORD_CAP    = 17;   // widest field a 15-bit frame size can ask for

   // configuration register map
   localparam int CSR_IDX_W    = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCODE_ANGLES = 2'd2;

   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 15'd640;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 15'd480;

   // record queue between classifier and packer
   localparam int QUEUE_DEPTH  = 2;

endpackage

// File: sv/kqbp_front.sv
// ----------------------------------------------------------------------------
// kqbp_front
// Accepts keypoints, quantizes them and builds one left-aligned record.
// ----------------------------------------------------------------------------
module kqbp_front #(
   parameter int COORD_W = 16,
   parameter int REC_W   = 51,
   parameter int LEN_W   = 6
) (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kqbp_pkg::X_POS_W-1:0]      req_x_pos,
   input  logic [kqbp_pkg::Y_POS_W-1:0]      req_y_pos,
   input  logic [kqbp_pkg::DIAM_W-1:0]       req_kp_diameter,
   input  logic signed [kqbp_pkg::ANGLE_IN_W-1:0] req_orientation,
   input  logic                              req_final_keypoint,
   input  logic [kqbp_pkg::FRAME_W-1:0]      frame_width,
   input  logic [kqbp_pkg::FRAME_W-1:0]      frame_height,
   input  logic                              encode_angles,
   input  logic                              queue_full,
   output logic                              push,
   output logic [REC_W-1:0]                  push_rec,
   output logic [LEN_W-1:0]                  push_len,
   output logic                              push_last
);
   import kqbp_pkg::*;

   localparam int CW = $clog2(COORD_W + 1);
   localparam int QW = COORD_CAP;
   localparam logic [LEN_W-1:0] REC_LEN = LEN_W'(REC_W);

   // field width = ceil(log2(dim)) + 2, saturated
   function automatic logic [CW-1:0] coord_bits(input logic [FRAME_W-1:0] dim);
      logic [FRAME_W-1:0] m;
      logic [4:0]         c;
      logic [5:0]         w;
      m = (dim == '0) ? '0 : dim - 1'b1;
      c = '0;
      for (int i = 0; i < FRAME_W; i++) begin
         if (m[i]) c = 5'(i + 1);
      end
      w = {1'b0, c} + 6'd2;
      if (w > 6'(COORD_W)) w = 6'(COORD_W);
      return CW'(w);
   endfunction

   logic [CW-1:0]           xw, yw;
   logic [X_POS_W:0]        x_sum;
   logic [Y_POS_W:0]        y_sum;
   logic [DIAM_W:0]         d_sum;
   logic [QW-1:0]           qx, qy, qy_mask;
   logic [SIZE_BITS-1:0]    qs;
   logic [ANGLE_IN_W-1:0]   a_mag;
   logic [ANGLE_IN_W:0]     a_sum;
   logic [9:0]              a_deg;
   logic [8:0]              a_mod;
   logic [8:0]              a_red;
   logic                    a_neg;
   logic [ANGLE_BITS-1:0]   a_field;
   logic [LEN_W-1:0]        xy_len, xys_len;

   always_comb begin
      xw      = coord_bits(frame_width);
      yw      = coord_bits(frame_height);

      // round half away from zero to quarter pixels
      x_sum   = {1'b0, req_x_pos} + (X_POS_W+1)'(2);
      y_sum   = {1'b0, req_y_pos} + (Y_POS_W+1)'(2);
      d_sum   = {1'b0, req_kp_diameter} + (DIAM_W+1)'(2);
      qx      = x_sum[X_POS_W:2];
      qy      = y_sum[Y_POS_W:2];
      qs      = d_sum[SIZE_BITS+1:2];
      qy_mask = ~({QW{1'b1}} << yw);

      // angle: whole degrees rounded half up, mod 360, fold positive angles above 180
      // magnitude is at most 8192, so whole degrees stay below 513
      a_neg   = req_orientation[ANGLE_IN_W-1];
      a_mag   = a_neg ? ANGLE_IN_W'(-req_orientation) : ANGLE_IN_W'(req_orientation);
      a_sum   = {1'b0, a_mag} + (ANGLE_IN_W+1)'(8);
      a_deg   = a_sum[ANGLE_IN_W-1:4];
      a_mod   = (a_deg >= 10'd360) ? 9'(a_deg - 10'd360) : a_deg[8:0];
      a_red   = (!a_neg && a_mod > 9'd180) ? a_mod - 9'd180 : a_mod;
      a_field = {a_neg && (a_red != '0), a_red[7:0]};

      xy_len  = LEN_W'(xw) + LEN_W'(yw);
      xys_len = xy_len + LEN_W'(SIZE_BITS);
      push_len = encode_angles ? xys_len + LEN_W'(ANGLE_BITS) : xys_len;

      // left-aligned record; upper bits of qx fall off the top
      push_rec = (REC_W'(qx) << (REC_LEN - LEN_W'(xw)))
               | (REC_W'(qy & qy_mask) << (REC_LEN - xy_len))
               | (REC_W'(qs) << (REC_LEN - xys_len));
      if (encode_angles) begin
         push_rec = push_rec | (REC_W'(a_field) << (REC_LEN - push_len));
      end

      push_last = req_final_keypoint;
      req_stall = queue_full;
      push      = req_valid && !queue_full;
   end

endmodule

// File: sv/kqbp_queue.sv
// ----------------------------------------------------------------------------
// kqbp_queue
// Short record queue between the classifier and the packer.
// ----------------------------------------------------------------------------
module kqbp_queue #(
   parameter int REC_W = 51,
   parameter int LEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [REC_W-1:0] push_rec,
   input  logic [LEN_W-1:0] push_len,
   input  logic             push_last,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output logic [REC_W-1:0] pop_rec,
   output logic [LEN_W-1:0] pop_len,
   output logic             pop_last
);
   import kqbp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [REC_W-1:0] rec_ff  [QUEUE_DEPTH];
   logic [LEN_W-1:0] len_ff  [QUEUE_DEPTH];
   logic             last_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   always_comb begin
      full      = (count_ff == CNT_W'(QUEUE_DEPTH));
      pop_valid = (count_ff != '0);
      do_pop    = pop && pop_valid;
      pop_rec   = rec_ff[rd_ptr_ff];
      pop_len   = len_ff[rd_ptr_ff];
      pop_last  = last_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rec_ff[wr_ptr_ff]  <= push_rec;
         len_ff[wr_ptr_ff]  <= push_len;
         last_ff[wr_ptr_ff] <= push_last;
      end
   end

endmodule

// File: sv/kqbp_back.sv
// ----------------------------------------------------------------------------
// kqbp_back
// Merges records with carried bits; drains one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module kqbp_back #(
   parameter int REC_W = 51,
   parameter int LEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop,
   input  logic [REC_W-1:0] pop_rec,
   input  logic [LEN_W-1:0] pop_len,
   input  logic             pop_last,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_stream_end
);
   import kqbp_pkg::*;

   localparam int ACC_W = REC_W + BYTE_BITS - 1;
   localparam logic [LEN_W-1:0] BYTE_LEN = LEN_W'(BYTE_BITS);

   logic [ACC_W-1:0]     acc_ff, acc_in, acc_sh, acc_load;
   logic [LEN_W-1:0]     n_ff, n_in, n_after;
   logic                 last_ff, last_in;
   logic                 busy_ff, busy_in;
   logic [7:0]           pb_ff, pb_in, pb_next, pb_src;
   logic [2:0]           nf_ff, nf_in, nf_next, nf_src;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic                 emit, finish;

   always_comb begin
      emit     = busy_ff && (!rsp_valid_ff || !rsp_stall);
      n_after  = (n_ff >= BYTE_LEN) ? n_ff - BYTE_LEN : '0;
      acc_sh   = acc_ff << BYTE_BITS;
      // record done once fewer than a byte remains and no flush is owed
      finish   = emit && (n_after < BYTE_LEN) && !(last_ff && n_after != '0);
      pb_next  = last_ff ? '0 : acc_sh[ACC_W-1 -: 8];
      nf_next  = last_ff ? '0 : n_after[2:0];

      pop      = pop_valid && (!busy_ff || finish);
      pb_src   = finish ? pb_next : pb_ff;
      nf_src   = finish ? nf_next : nf_ff;
      acc_load = {pb_src, {(ACC_W-8){1'b0}}} | ({pop_rec, {(BYTE_BITS-1){1'b0}}} >> nf_src);

      acc_in   = acc_ff;
      n_in     = n_ff;
      last_in  = last_ff;
      busy_in  = busy_ff;
      pb_in    = finish ? pb_next : pb_ff;
      nf_in    = finish ? nf_next : nf_ff;
      priority if (pop) begin
         acc_in  = acc_load;
         n_in    = LEN_W'(nf_src) + pop_len;
         last_in = pop_last;
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (emit) begin
         acc_in  = acc_sh;
         n_in    = n_after;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = acc_ff[ACC_W-1 -: 8];
         rsp_end_in   = last_ff && (n_after == '0);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pb_ff        <= '0;
         nf_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pb_ff        <= pb_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      n_ff        <= n_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_stream_end = rsp_end_ff;

`ifndef SYNTH
   a_busy_has_bits: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (n_ff != '0))
      else $error("packer busy with no pending bits");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (n_ff <= LEN_W'(ACC_W)))
      else $error("pending bit count beyond accumulator");
   a_end_on_flush: assert property (@(posedge clock) disable iff (reset)
      (finish && last_ff) |=> (rsp_valid_ff && rsp_end_ff))
      else $error("final record closed without end mark");
   a_carry_clear: assert property (@(posedge clock) disable iff (reset)
      (finish && last_ff) |=> (nf_ff == '0 && pb_ff == '0))
      else $error("carry bits survive end of stream");
`endif

endmodule

// File: sv/keypoint_quantize_bit_packer.sv
// ----------------------------------------------------------------------------
// keypoint_quantize_bit_packer
// Quantizes keypoints to quarter pixels and packs them MSB-first into bytes.
//
// req_* : one keypoint per word (valid/stall). x, y and size are rounded to
//         quarter pixels; an optional 9-bit angle follows. Accepted whenever
//         the two-entry record queue has room, also while bytes still drain.
// rsp_* : one packed byte per word, earliest bit in bit 7. rsp_stream_end
//         marks the last byte after a final keypoint (partial byte padded).
// csr_* : register writes (frame_width, frame_height, encode_angles); always
//         ready; the user must write them only while the block is idle, as
//         the block itself does not enforce it.
// Throughput: one byte per cycle from the packer's byte shifter while rsp is
//   not stalled; a keypoint is queued, loaded into the accumulator and yields
//   1 to 8 bytes (about 7 for full-width records with angles).
// Reset: synchronous; registers return to 640/480/0 and carried bits clear.
// A stall on rsp holds the output byte; the queue keeps taking keypoints
// until it is full, then req_stall rises.
// ----------------------------------------------------------------------------
module keypoint_quantize_bit_packer #(
   parameter int MAX_COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // keypoint input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [kqbp_pkg::X_POS_W-1:0]           req_x_pos,
   input  logic [kqbp_pkg::Y_POS_W-1:0]           req_y_pos,
   input  logic [kqbp_pkg::DIAM_W-1:0]            req_kp_diameter,
   input  logic signed [kqbp_pkg::ANGLE_IN_W-1:0] req_orientation,
   input  logic                                   req_final_keypoint,
   // byte output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_stream_end,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kqbp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [kqbp_pkg::FRAME_W-1:0]           csr_data
);
   import kqbp_pkg::*;

   // coordinate fields never need more than COORD_CAP bits
   localparam int COORD_W = (MAX_COORD_BITS < COORD_CAP) ? MAX_COORD_BITS : COORD_CAP;
   localparam int REC_W   = 2 * COORD_W + SIZE_BITS + ANGLE_BITS;
   localparam int LEN_W   = $clog2(REC_W + BYTE_BITS);

   logic [FRAME_W-1:0] frame_width_ff, frame_width_in;
   logic [FRAME_W-1:0] frame_height_ff, frame_height_in;
   logic               encode_angles_ff, encode_angles_in;

   logic               push, queue_full, pop_valid, pop;
   logic [REC_W-1:0]   push_rec, pop_rec;
   logic [LEN_W-1:0]   push_len, pop_len;
   logic               push_last, pop_last;

   // register file; unknown indexes drop the write
   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      encode_angles_in = encode_angles_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_in   = csr_data;
            CSR_FRAME_HEIGHT:  frame_height_in  = csr_data;
            CSR_ENCODE_ANGLES: encode_angles_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         encode_angles_ff <= 1'b0;
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         encode_angles_ff <= encode_angles_in;
      end
   end

   // classify: quantize and build the left-aligned record
   kqbp_front #(
      .COORD_W (COORD_W),
      .REC_W   (REC_W),
      .LEN_W   (LEN_W)
   ) u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_x_pos          (req_x_pos),
      .req_y_pos          (req_y_pos),
      .req_kp_diameter    (req_kp_diameter),
      .req_orientation    (req_orientation),
      .req_final_keypoint (req_final_keypoint),
      .frame_width        (frame_width_ff),
      .frame_height       (frame_height_ff),
      .encode_angles      (encode_angles_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_rec           (push_rec),
      .push_len           (push_len),
      .push_last          (push_last)
   );

   // decouples intake from byte draining
   kqbp_queue #(
      .REC_W (REC_W),
      .LEN_W (LEN_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .push_len  (push_len),
      .push_last (push_last),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_rec   (pop_rec),
      .pop_len   (pop_len),
      .pop_last  (pop_last)
   );

   // pack: merge with carried bits, one byte per cycle unless rsp stalls
   kqbp_back #(
      .REC_W (REC_W),
      .LEN_W (LEN_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop            (pop),
      .pop_rec        (pop_rec),
      .pop_len        (pop_len),
      .pop_last       (pop_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule
